FILE: sv/assert_macros.svh
// Assertion helpers used by the loss core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCEL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SCEL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/scel_pkg.sv
// ----------------------------------------------------------------------------
// scel_pkg
// Shared constants, codes and lookup tables of the softmax cross-entropy core.
// ----------------------------------------------------------------------------
package scel_pkg;

  // Row storage sizing.
  localparam int MAX_VOCAB = 4096;
  localparam int ADDR_W    = $clog2(MAX_VOCAB);
  localparam int CNT_W     = $clog2(MAX_VOCAB + 1);

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Divider widths and the fixed dividend 2^47.
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 32;
  localparam logic [DIV_N_W-1:0] DIV_DIVIDEND = 48'h8000_0000_0000;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BATCH_ROWS = 2'd0;
  localparam logic [1:0] CFG_INV_BATCH  = 2'd1;
  localparam logic [1:0] CFG_UPSTREAM   = 2'd2;

  // Operation, result kind and status codes.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_GRAD = 1'b1;
  localparam logic KIND_LOSS = 1'b0;
  localparam logic KIND_GRAD = 1'b1;
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_TGT = 2'd1;
  localparam logic [1:0] STAT_BAD_IDX = 2'd2;

  // 2^(-i/16) in Q1.16.
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // log2(1 + i/16) in Q1.16.
  function automatic logic [16:0] log2_tab(input logic [4:0] i);
    logic [16:0] v;
    unique case (i)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/scel_if.sv
// ----------------------------------------------------------------------------
// scel_if
// Valid/ready channels of the loss core: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface scel_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [23:0] logit;
  logic        [11:0] target;
  logic               last_in_row;
  logic        [11:0] elem_index;

  modport source (output valid, op, logit, target, last_in_row, elem_index, input ready);
  modport sink   (input valid, op, logit, target, last_in_row, elem_index, output ready);
endinterface

interface scel_rsp_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic        [31:0] row_loss;
  logic        [31:0] mean_loss;
  logic               batch_end;
  logic signed [23:0] gradient;
  logic        [1:0]  status;

  modport source (output valid, kind, row_loss, mean_loss, batch_end, gradient, status,
                  input ready);
  modport sink   (input valid, kind, row_loss, mean_loss, batch_end, gradient, status,
                  output ready);
endinterface

FILE: sv/scel_ram.sv
// ----------------------------------------------------------------------------
// scel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scel_ram #(
  parameter int W = 24,
  parameter int D = 4096
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/scel_mul.sv
// ----------------------------------------------------------------------------
// scel_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module scel_mul (
  input  logic                                clk,
  input  logic signed [scel_pkg::MUL_W-1:0]  a,
  input  logic signed [scel_pkg::MUL_W-1:0]  b,
  output logic signed [scel_pkg::PROD_W-1:0] prod
);

  // One product per cycle, result available on the next cycle.
  always_ff @(posedge clk) begin
    prod <= scel_pkg::PROD_W'(a) * scel_pkg::PROD_W'(b);
  end

endmodule

FILE: sv/scel_div.sv
// ----------------------------------------------------------------------------
// scel_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module scel_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [scel_pkg::DIV_N_W-1:0]     dividend,
  input  logic [scel_pkg::DIV_D_W-1:0]     divisor,
  output logic                             busy,
  output logic [scel_pkg::DIV_N_W-1:0]     quotient
);

  localparam int CW = $clog2(scel_pkg::DIV_N_W + 1);

  logic [scel_pkg::DIV_D_W:0]   rem;
  logic [scel_pkg::DIV_D_W-1:0] dvs;
  logic [CW-1:0]                cnt;
  logic [scel_pkg::DIV_D_W:0]   rem_sh;
  logic                         fits;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    rem_sh = {rem[scel_pkg::DIV_D_W-1:0], quotient[scel_pkg::DIV_N_W-1]};
    fits   = rem_sh >= {1'b0, dvs};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(scel_pkg::DIV_N_W);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      quotient <= {quotient[scel_pkg::DIV_N_W-2:0], fits};
    end
  end

endmodule

FILE: sv/softmax_cross_entropy_loss_core.sv
// ----------------------------------------------------------------------------
// softmax_cross_entropy_loss_core
// Streaming softmax cross-entropy loss with batch mean and gradient queries.
//
//   channel | dir | beat contents
//   req     | in  | op, logit, target, last_in_row, elem_index
//   rsp     | out | kind, row_loss, mean_loss, batch_end, gradient, status
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A logit push runs on the shared multiplier and exp table.
// A row end adds the normalize, log and mean steps, and waits on the divider.
// A gradient query goes through the RAM read and five products; a refused query skips them.
// Reset is synchronous and clears all control state; the row RAM is not cleared.
// A new request is taken while a result waits on rsp; a result stalls on rsp only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module softmax_cross_entropy_loss_core (
  input  logic        clk,
  input  logic        rst,
  scel_req_if.sink    req,
  scel_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_PUSH   = 5'd1;
  localparam logic [4:0] ST_E1     = 5'd2;
  localparam logic [4:0] ST_E2     = 5'd3;
  localparam logic [4:0] ST_E3     = 5'd4;
  localparam logic [4:0] ST_E4     = 5'd5;
  localparam logic [4:0] ST_UP1    = 5'd6;
  localparam logic [4:0] ST_UP2    = 5'd7;
  localparam logic [4:0] ST_ADD    = 5'd8;
  localparam logic [4:0] ST_ENDCHK = 5'd9;
  localparam logic [4:0] ST_NORM   = 5'd10;
  localparam logic [4:0] ST_L1     = 5'd11;
  localparam logic [4:0] ST_L2     = 5'd12;
  localparam logic [4:0] ST_L3     = 5'd13;
  localparam logic [4:0] ST_L4     = 5'd14;
  localparam logic [4:0] ST_TGT    = 5'd15;
  localparam logic [4:0] ST_LOSS   = 5'd16;
  localparam logic [4:0] ST_ACC    = 5'd17;
  localparam logic [4:0] ST_M1     = 5'd18;
  localparam logic [4:0] ST_M2     = 5'd19;
  localparam logic [4:0] ST_M3     = 5'd20;
  localparam logic [4:0] ST_WDIV   = 5'd21;
  localparam logic [4:0] ST_EMIT   = 5'd22;
  localparam logic [4:0] ST_GQ     = 5'd23;
  localparam logic [4:0] ST_G1     = 5'd24;
  localparam logic [4:0] ST_G2     = 5'd25;
  localparam logic [4:0] ST_G3     = 5'd26;
  localparam logic [4:0] ST_G4     = 5'd27;
  localparam logic [4:0] ST_G5     = 5'd28;
  localparam logic [4:0] ST_G6     = 5'd29;

  localparam logic [1:0] RET_UP   = 2'd0;
  localparam logic [1:0] RET_ADD  = 2'd1;
  localparam logic [1:0] RET_GRAD = 2'd2;

  localparam int AW = scel_pkg::ADDR_W;
  localparam int CW = scel_pkg::CNT_W;
  localparam int MW = scel_pkg::MUL_W;
  localparam int PW = scel_pkg::PROD_W;

  // Sequencer and configuration.
  logic [4:0]         state;
  logic [1:0]         ret;
  logic [15:0]        batch_rows;
  logic [24:0]        inv_batch_rows;
  logic signed [23:0] upstream_grad;

  // Row state.
  logic [11:0]        row_target;
  logic [CW-1:0]      elem_count;
  logic               row_ready;
  logic signed [23:0] running_max;
  logic [31:0]        exp_sum;
  logic [31:0]        inv_exp_sum;
  logic [47:0]        loss_total;
  logic [15:0]        rows_seen;

  // Working registers of the current item.
  logic signed [23:0] x_q;
  logic               last_q;
  logic [11:0]        idx_q;
  logic [23:0]        d_q;
  logic [8:0]         ek;
  logic [3:0]         ei;
  logic [11:0]        er;
  logic [16:0]        e_q;
  logic [31:0]        nm;
  logic [4:0]         np;
  logic [20:0]        lg_q;
  logic [20:0]        ln_q;
  logic [48:0]        mhi;
  logic signed [23:0] p_q;
  logic signed [32:0] scale_q;

  // Pending result and output register.
  logic               res_kind;
  logic [31:0]        res_loss;
  logic [31:0]        res_mean;
  logic               res_bend;
  logic signed [23:0] res_grad;
  logic [1:0]         res_status;
  logic               out_valid;
  logic               out_kind;
  logic [31:0]        out_loss;
  logic [31:0]        out_mean;
  logic               out_bend;
  logic signed [23:0] out_grad;
  logic [1:0]         out_status;

  // Shared units.
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic signed [23:0]   ram_rd;
  logic                 div_start;
  logic                 div_busy;
  logic [scel_pkg::DIV_N_W-1:0] div_q;

  // Combinational helpers.
  logic [3:0]         li;
  logic [11:0]        lr;
  logic [16:0]        ev;
  logic [16:0]        lv;
  logic [33:0]        s_up;
  logic [32:0]        s_add;
  logic signed [33:0] lsum;
  logic [48:0]        s_acc;
  logic [47:0]        lt_new;
  logic [15:0]        need;
  logic [49:0]        m_sum;
  logic signed [41:0] gw;
  logic               push_fits;
  logic               tgt_ok;
  logic               idx_ok;

  scel_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  scel_ram #(.W(24), .D(scel_pkg::MAX_VOCAB)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (elem_count[AW-1:0]),
    .wdata (x_q),
    .raddr (ram_raddr),
    .rdata (ram_rd)
  );

  scel_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (scel_pkg::DIV_DIVIDEND),
    .divisor  (exp_sum),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Handshake and output drive.
  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.kind      = out_kind;
  assign rsp.row_loss  = out_loss;
  assign rsp.mean_loss = out_mean;
  assign rsp.batch_end = out_bend;
  assign rsp.gradient  = out_grad;
  assign rsp.status    = out_status;

  // Unit controls and arithmetic decoded from the sequencer state.
  always_comb begin
    push_fits = 32'(elem_count) < 32'(scel_pkg::MAX_VOCAB);
    tgt_ok    = 32'(row_target) < 32'(elem_count);
    idx_ok    = row_ready && (32'(idx_q) < 32'(elem_count));
    ram_we    = (state == ST_PUSH) && push_fits;
    ram_raddr = (state == ST_TGT) ? AW'(row_target) : AW'(idx_q);
    div_start = (state == ST_ENDCHK) && last_q;

    li = nm[30:27];
    lr = nm[26:15];
    ev = scel_pkg::exp2_tab({1'b0, ei}) - prod[28:12];
    lv = scel_pkg::log2_tab({1'b0, li}) + prod[28:12];

    s_up   = {2'b00, prod[47:16]} + 34'd65536;
    s_add  = 33'(exp_sum) + 33'(e_q);
    lsum   = $signed({13'b0, ln_q}) + 34'(running_max) - 34'(ram_rd);
    s_acc  = 49'(loss_total) + 49'(res_loss);
    lt_new = s_acc[48] ? '1 : s_acc[47:0];
    need   = (batch_rows == 16'd0) ? 16'd1 : batch_rows;
    m_sum  = 50'(mhi) + 50'(prod[48:24]);
    gw     = prod[65:24];

    unique case (state)
      ST_E1: begin
        mul_a = MW'(d_q);
        mul_b = MW'(94548);
      end
      ST_E3: begin
        mul_a = MW'(scel_pkg::exp2_tab({1'b0, ei})
                    - scel_pkg::exp2_tab(5'({1'b0, ei}) + 5'd1));
        mul_b = MW'(er);
      end
      ST_UP1: begin
        mul_a = MW'(exp_sum);
        mul_b = MW'(e_q);
      end
      ST_L1: begin
        mul_a = MW'(scel_pkg::log2_tab(5'({1'b0, li}) + 5'd1)
                    - scel_pkg::log2_tab({1'b0, li}));
        mul_b = MW'(lr);
      end
      ST_L3: begin
        mul_a = MW'(lg_q);
        mul_b = MW'(45426);
      end
      ST_M1: begin
        mul_a = MW'(loss_total[47:24]);
        mul_b = MW'(inv_batch_rows);
      end
      ST_M2: begin
        mul_a = MW'(loss_total[23:0]);
        mul_b = MW'(inv_batch_rows);
      end
      ST_G2: begin
        mul_a = MW'(e_q);
        mul_b = MW'(inv_exp_sum);
      end
      ST_G3: begin
        mul_a = MW'(upstream_grad);
        mul_b = MW'(inv_batch_rows);
      end
      ST_G5: begin
        mul_a = MW'(scale_q);
        mul_b = MW'(p_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_rows     <= 16'd1;
      inv_batch_rows <= 25'd16777216;
      upstream_grad  <= 24'sd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scel_pkg::CFG_BATCH_ROWS: batch_rows     <= cfg_data[15:0];
        scel_pkg::CFG_INV_BATCH:  inv_batch_rows <= cfg_data;
        scel_pkg::CFG_UPSTREAM:   upstream_grad  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Sequencer with row state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      ret         <= RET_UP;
      row_target  <= '0;
      elem_count  <= '0;
      row_ready   <= 1'b0;
      running_max <= 24'sh800000;
      exp_sum     <= '0;
      inv_exp_sum <= '0;
      loss_total  <= '0;
      rows_seen   <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The output register fills from the emit step and empties on a taken beat.
      if ((state == ST_EMIT) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            x_q    <= req.logit;
            last_q <= req.last_in_row;
            idx_q  <= req.elem_index;
            if (req.op == scel_pkg::OP_PUSH) begin
              if (row_ready || elem_count == '0) begin
                row_ready  <= 1'b0;
                elem_count <= '0;
                row_target <= req.target;
              end
              state <= ST_PUSH;
            end else begin
              state <= ST_GQ;
            end
          end
        end
        // Store the logit and pick the online softmax update.
        ST_PUSH: begin
          if (!push_fits) begin
            state <= ST_ENDCHK;
          end else begin
            elem_count <= elem_count + CW'(1);
            if (elem_count == '0) begin
              running_max <= x_q;
              exp_sum     <= 32'd65536;
              state       <= ST_ENDCHK;
            end else if (x_q > running_max) begin
              d_q   <= 24'(25'(x_q) - 25'(running_max));
              ret   <= RET_UP;
              state <= ST_E1;
            end else begin
              d_q   <= 24'(25'(running_max) - 25'(x_q));
              ret   <= RET_ADD;
              state <= ST_E1;
            end
          end
        end
        // exp(-d): scale by log2(e), then interpolate 2^-f and shift.
        ST_E1: state <= ST_E2;
        ST_E2: begin
          ek    <= prod[40:32];
          ei    <= prod[31:28];
          er    <= prod[27:16];
          state <= ST_E3;
        end
        ST_E3: state <= ST_E4;
        ST_E4: begin
          e_q <= (ek >= 9'd17) ? 17'd0 : (ev >> ek);
          unique case (ret)
            RET_UP:   state <= ST_UP1;
            RET_ADD:  state <= ST_ADD;
            RET_GRAD: state <= ST_G2;
            default:  state <= ST_IDLE;
          endcase
        end
        // New maximum: rescale the sum and add one.
        ST_UP1: state <= ST_UP2;
        ST_UP2: begin
          exp_sum     <= (s_up[33:32] != 2'b00) ? '1 : s_up[31:0];
          running_max <= x_q;
          state       <= ST_ENDCHK;
        end
        ST_ADD: begin
          exp_sum <= s_add[32] ? '1 : s_add[31:0];
          state   <= ST_ENDCHK;
        end
        // Row end: start the reciprocal and normalize the sum for the log.
        ST_ENDCHK: begin
          if (!last_q) begin
            state <= ST_IDLE;
          end else begin
            row_ready <= 1'b1;
            nm        <= exp_sum;
            np        <= 5'd31;
            res_kind  <= scel_pkg::KIND_LOSS;
            res_grad  <= '0;
            state     <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (exp_sum < 32'd65536) begin
            ln_q  <= '0;
            state <= ST_TGT;
          end else if (nm[31]) begin
            state <= ST_L1;
          end else begin
            nm <= {nm[30:0], 1'b0};
            np <= np - 5'd1;
          end
        end
        ST_L1: state <= ST_L2;
        ST_L2: begin
          lg_q  <= 21'({4'(np - 5'd16), 16'h0000}) + 21'(lv);
          state <= ST_L3;
        end
        ST_L3: state <= ST_L4;
        ST_L4: begin
          ln_q  <= prod[36:16];
          state <= ST_TGT;
        end
        // Row loss from the stored target logit.
        ST_TGT: begin
          if (tgt_ok) begin
            state <= ST_LOSS;
          end else begin
            res_loss   <= '0;
            res_status <= scel_pkg::STAT_BAD_TGT;
            state      <= ST_ACC;
          end
        end
        ST_LOSS: begin
          res_loss   <= lsum[33] ? 32'd0 : (lsum[32] ? '1 : lsum[31:0]);
          res_status <= scel_pkg::STAT_OK;
          state      <= ST_ACC;
        end
        // Batch accumulation and mean.
        ST_ACC: begin
          loss_total <= lt_new;
          if (17'(rows_seen) + 17'd1 >= 17'(need)) begin
            state <= ST_M1;
          end else begin
            rows_seen <= rows_seen + 16'd1;
            res_mean  <= '0;
            res_bend  <= 1'b0;
            state     <= ST_WDIV;
          end
        end
        ST_M1: state <= ST_M2;
        ST_M2: begin
          mhi   <= prod[48:0];
          state <= ST_M3;
        end
        ST_M3: begin
          res_mean   <= (m_sum[49:32] != '0) ? '1 : m_sum[31:0];
          res_bend   <= 1'b1;
          loss_total <= '0;
          rows_seen  <= '0;
          state      <= ST_WDIV;
        end
        ST_WDIV: begin
          if (!div_busy) begin
            inv_exp_sum <= (exp_sum == '0) ? '0 : div_q[31:0];
            state       <= ST_EMIT;
          end
        end
        // Hand the result to the output register once it is free.
        ST_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_kind   <= res_kind;
            out_loss   <= res_loss;
            out_mean   <= res_mean;
            out_bend   <= res_bend;
            out_grad   <= res_grad;
            out_status <= res_status;
            state      <= ST_IDLE;
          end
        end
        // Gradient query.
        ST_GQ: begin
          res_kind <= scel_pkg::KIND_GRAD;
          res_loss <= '0;
          res_mean <= '0;
          res_bend <= 1'b0;
          res_grad <= '0;
          if (idx_ok) begin
            res_status <= scel_pkg::STAT_OK;
            state      <= ST_G1;
          end else begin
            res_status <= scel_pkg::STAT_BAD_IDX;
            state      <= ST_EMIT;
          end
        end
        ST_G1: begin
          d_q   <= 24'(25'(running_max) - 25'(ram_rd));
          ret   <= RET_GRAD;
          state <= ST_E1;
        end
        ST_G2: state <= ST_G3;
        ST_G3: begin
          p_q   <= 24'(prod[47:25])
                   - ((idx_q == row_target) ? 24'sh400000 : 24'sh000000);
          state <= ST_G4;
        end
        // The scale reaches 33 signed bits at the extremes of the seed and reciprocal.
        ST_G4: begin
          scale_q <= prod[48:16];
          state   <= ST_G5;
        end
        ST_G5: state <= ST_G6;
        ST_G6: begin
          if (gw > 42'sd8388607) begin
            res_grad <= 24'sh7FFFFF;
          end else if (gw < -42'sd8388608) begin
            res_grad <= 24'sh800000;
          end else begin
            res_grad <= gw[23:0];
          end
          state <= ST_EMIT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A finished row always holds at least one element.
  `SCEL_ASSERT_IMP(a_ready_nonempty, clk, rst, row_ready, elem_count != '0, "empty row finished")
  // The element count never passes the row capacity.
  `SCEL_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, 32'(elem_count) <= 32'(scel_pkg::MAX_VOCAB), "row count overflow")
  // A stalled result is never overwritten by the next one.
  `SCEL_ASSERT_NXT(a_no_overwrite, clk, rst, (state == ST_EMIT) && rsp.valid && !rsp.ready, state == ST_EMIT, "result overwritten")

endmodule
